// ===== hdl/sha1sh_pkg.sv =====
// Shared types, constants and codes of the SHA-1 stream hasher.
package sha1sh_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned HashWords  = 5;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned BlockBits  = BlockBytes * 8;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned LenBits    = 64;
  localparam int unsigned IdxBits    = $clog2(BlockBytes);
  localparam int unsigned RoundBits  = $clog2(Rounds);

  localparam logic [7:0]         PadByte     = 8'h80;
  localparam logic [IdxBits-1:0] LenStartIdx = IdxBits'(56);
  localparam logic [IdxBits-1:0] LastIdx     = IdxBits'(BlockBytes - 1);
  localparam logic [RoundBits-1:0] LastRound = RoundBits'(Rounds - 1);

  localparam logic [HashWords-1:0][WordBits-1:0] InitHash = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [3:0][WordBits-1:0] RoundK = {
    32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [WordBits-1:0] digest_word;
    logic                digest_last;
  } out_req_t;

  typedef enum logic [1:0] {
    BS_DATA,
    BS_PAD,
    BS_ZERO,
    BS_LEN
  } byte_sel_e;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } round_phase_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic         load_byte;
    byte_sel_e    byte_sel;
    logic         count_len;
    logic         start;
    logic         round;
    round_phase_e phase;
    logic         add;
    logic         out_load;
    logic         out_last;
    logic         clear;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic idx_len;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/sha1sh_datapath.sv =====
// Datapath: block buffer and schedule, round registers, chaining value, length, output register.
module sha1sh_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha1sh_pkg::in_req_t  in_req_i,
  input  sha1sh_pkg::dp_cmd_t  cmd_i,
  output sha1sh_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sha1sh_pkg::out_req_t out_req_o
);

  localparam int unsigned W  = sha1sh_pkg::WordBits;
  localparam int unsigned BB = sha1sh_pkg::BlockBits;

  logic [BB-1:0] sched_q, sched_d;
  logic [W-1:0]  a_q, b_q, c_q, d_q, e_q;
  logic [W-1:0]  a_d, b_d, c_d, d_d, e_d;
  logic [sha1sh_pkg::HashWords-1:0][W-1:0] cv_q, cv_d;
  logic [sha1sh_pkg::LenBits-1:0] len_q, len_d;
  logic [sha1sh_pkg::IdxBits-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  sha1sh_pkg::out_req_t out_q, out_d;

  logic [7:0]   byte_in;
  logic [W-1:0] w_cur, w_mix, w_new, f_val, k_val, tmp;

  always_comb begin
    case (cmd_i.byte_sel)
      sha1sh_pkg::BS_DATA: byte_in = in_req_i.data_byte;
      sha1sh_pkg::BS_PAD:  byte_in = sha1sh_pkg::PadByte;
      sha1sh_pkg::BS_ZERO: byte_in = 8'h00;
      sha1sh_pkg::BS_LEN:  byte_in = len_q[sha1sh_pkg::LenBits-1 -: 8];
      default:             byte_in = 8'h00;
    endcase
  end

  assign w_cur = sched_q[BB-1 -: W];
  assign w_mix = sched_q[BB-1 -: W] ^ sched_q[BB-1-2*W -: W]
               ^ sched_q[BB-1-8*W -: W] ^ sched_q[BB-1-13*W -: W];
  assign w_new = {w_mix[W-2:0], w_mix[W-1]};

  always_comb begin
    case (cmd_i.phase)
      sha1sh_pkg::PH_CH:  f_val = (b_q & c_q) ^ (~b_q & d_q);
      sha1sh_pkg::PH_MAJ: f_val = (b_q & c_q) ^ (b_q & d_q) ^ (c_q & d_q);
      default:            f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  assign k_val = sha1sh_pkg::RoundK[cmd_i.phase];
  assign tmp   = {a_q[W-6:0], a_q[W-1:W-5]} + f_val + e_q + k_val + w_cur;

  always_comb begin
    sched_d = sched_q;
    if (cmd_i.load_byte) begin
      sched_d = {sched_q[BB-9:0], byte_in};
    end else if (cmd_i.round) begin
      sched_d = {sched_q[BB-W-1:0], w_new};
    end
  end

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    if (cmd_i.start) begin
      a_d = cv_q[0];
      b_d = cv_q[1];
      c_d = cv_q[2];
      d_d = cv_q[3];
      e_d = cv_q[4];
    end else if (cmd_i.round) begin
      a_d = tmp;
      b_d = a_q;
      c_d = {b_q[1:0], b_q[W-1:2]};
      d_d = c_q;
      e_d = d_q;
    end
  end

  always_comb begin
    cv_d = cv_q;
    if (cmd_i.clear) begin
      cv_d = sha1sh_pkg::InitHash;
    end else if (cmd_i.add) begin
      cv_d[0] = cv_q[0] + a_q;
      cv_d[1] = cv_q[1] + b_q;
      cv_d[2] = cv_q[2] + c_q;
      cv_d[3] = cv_q[3] + d_q;
      cv_d[4] = cv_q[4] + e_q;
    end else if (cmd_i.out_load) begin
      for (int i = 0; i < sha1sh_pkg::HashWords - 1; i++) begin
        cv_d[i] = cv_q[i+1];
      end
    end
  end

  always_comb begin
    len_d = len_q;
    if (cmd_i.clear) begin
      len_d = '0;
    end else if (cmd_i.count_len) begin
      len_d = len_q + sha1sh_pkg::LenBits'(8);
    end else if (cmd_i.load_byte && cmd_i.byte_sel == sha1sh_pkg::BS_LEN) begin
      len_d = {len_q[sha1sh_pkg::LenBits-9:0], 8'h00};
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clear) begin
      idx_d = '0;
    end else if (cmd_i.load_byte) begin
      idx_d = idx_q + sha1sh_pkg::IdxBits'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.out_load) begin
      out_valid_d       = 1'b1;
      out_d.digest_word = cv_q[0];
      out_d.digest_last = cmd_i.out_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q        <= sha1sh_pkg::InitHash;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cv_q        <= cv_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    d_q     <= d_d;
    e_q     <= e_d;
    out_q   <= out_d;
  end

  assign status_o.idx_last = (idx_q == sha1sh_pkg::LastIdx);
  assign status_o.idx_len  = (idx_q == sha1sh_pkg::LenStartIdx);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== hdl/sha1sh_ctrl.sv =====
// Controller: sequences byte loading, padding, rounds and digest output.
module sha1sh_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sha1sh_pkg::in_req_t    in_req_i,
  input  sha1sh_pkg::dp_status_t status_i,
  output sha1sh_pkg::dp_cmd_t    cmd_o
);

  sha1sh_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [sha1sh_pkg::RoundBits-1:0] round_q, round_d;
  logic [2:0] cnt_q, cnt_d;
  logic       accept, wrap;

  assign accept = in_valid_i && (state_q == sha1sh_pkg::ST_LOAD);
  assign wrap   = accept && in_req_i.byte_present && status_i.idx_last;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    round_d = round_q;
    cnt_d   = cnt_q;
    case (state_q)
      sha1sh_pkg::ST_LOAD: begin
        if (wrap) begin
          state_d = sha1sh_pkg::ST_ROUND;
          ret_d   = in_req_i.end_of_message ? sha1sh_pkg::ST_PAD80 : sha1sh_pkg::ST_LOAD;
        end else if (accept && in_req_i.end_of_message) begin
          state_d = sha1sh_pkg::ST_PAD80;
        end
      end
      sha1sh_pkg::ST_PAD80: begin
        state_d = status_i.idx_last ? sha1sh_pkg::ST_ROUND : sha1sh_pkg::ST_PADZ;
        ret_d   = sha1sh_pkg::ST_PADZ;
      end
      sha1sh_pkg::ST_PADZ: begin
        if (status_i.idx_len) begin
          state_d = sha1sh_pkg::ST_PADLEN;
          cnt_d   = '0;
        end else if (status_i.idx_last) begin
          state_d = sha1sh_pkg::ST_ROUND;
          ret_d   = sha1sh_pkg::ST_PADZ;
        end
      end
      sha1sh_pkg::ST_PADLEN: begin
        cnt_d = cnt_q + 3'd1;
        if (status_i.idx_last) begin
          state_d = sha1sh_pkg::ST_ROUND;
          ret_d   = sha1sh_pkg::ST_OUT;
          cnt_d   = '0;
        end
      end
      sha1sh_pkg::ST_ROUND: begin
        round_d = round_q + sha1sh_pkg::RoundBits'(1);
        if (round_q == sha1sh_pkg::LastRound) begin
          round_d = '0;
          state_d = sha1sh_pkg::ST_ADD;
        end
      end
      sha1sh_pkg::ST_ADD: begin
        state_d = ret_q;
      end
      sha1sh_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'(sha1sh_pkg::HashWords - 1)) begin
            cnt_d   = '0;
            state_d = sha1sh_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = sha1sh_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.byte_sel = sha1sh_pkg::BS_DATA;
    cmd_o.phase    = sha1sh_pkg::PH_CH;
    in_stall_o     = (state_q != sha1sh_pkg::ST_LOAD);
    case (state_q)
      sha1sh_pkg::ST_LOAD: begin
        cmd_o.load_byte = accept && in_req_i.byte_present;
        cmd_o.count_len = accept && in_req_i.byte_present;
        cmd_o.start     = wrap;
      end
      sha1sh_pkg::ST_PAD80: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_sel  = sha1sh_pkg::BS_PAD;
        cmd_o.start     = status_i.idx_last;
      end
      sha1sh_pkg::ST_PADZ: begin
        cmd_o.load_byte = !status_i.idx_len;
        cmd_o.byte_sel  = sha1sh_pkg::BS_ZERO;
        cmd_o.start     = !status_i.idx_len && status_i.idx_last;
      end
      sha1sh_pkg::ST_PADLEN: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_sel  = sha1sh_pkg::BS_LEN;
        cmd_o.start     = status_i.idx_last;
      end
      sha1sh_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (round_q >= sha1sh_pkg::RoundBits'(60)) begin
          cmd_o.phase = sha1sh_pkg::PH_PAR2;
        end else if (round_q >= sha1sh_pkg::RoundBits'(40)) begin
          cmd_o.phase = sha1sh_pkg::PH_MAJ;
        end else if (round_q >= sha1sh_pkg::RoundBits'(20)) begin
          cmd_o.phase = sha1sh_pkg::PH_PAR1;
        end else begin
          cmd_o.phase = sha1sh_pkg::PH_CH;
        end
      end
      sha1sh_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
      end
      sha1sh_pkg::ST_OUT: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_last = (cnt_q == 3'(sha1sh_pkg::HashWords - 1));
        cmd_o.clear    = status_i.out_free && cmd_o.out_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1sh_pkg::ST_LOAD;
      ret_q   <= sha1sh_pkg::ST_LOAD;
      round_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      round_q <= round_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/sha1_stream_hasher_top.sv =====
// Top level of the SHA-1 stream hasher: controller and datapath.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+------------------------------------
//   input   | in_valid_i | in_stall_o  | in_req_i  (data_byte, flags)
//   output  | out_valid_o| out_stall_i | out_req_o (digest_word, last)
//
// A byte is taken each cycle while loading; the 64th byte of a block starts
// the compression rounds and then the add into the chaining value, with the input stalled.
// An end request adds padding bytes, the message length and one or two block compressions,
// then five digest words leave one per cycle unless the output is stalled.
// Reset loads the initial chaining value and clears length and byte position.
module sha1_stream_hasher_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sha1sh_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sha1sh_pkg::out_req_t out_req_o
);

  sha1sh_pkg::dp_cmd_t    cmd;
  sha1sh_pkg::dp_status_t status;

  sha1sh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sha1sh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
